>>> hdl/nmea_rmc_stream_field_splitter_defines.svh
// ----------------------------------------------------------------------------
// nmea_rmc_stream_field_splitter_defines
// assertion macros for the splitter rtl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_STREAM_FIELD_SPLITTER_DEFINES_SVH
`define NMEA_RMC_STREAM_FIELD_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define NRMC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("nrmc assertion failed");

// checked at every edge, reset included
`define NRMC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("nrmc assertion failed");

`else

`define NRMC_ASSERT(label, prop)
`define NRMC_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> hdl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg
// constants, codes and types of the rmc field splitter
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam int SENTENCE_BUFFER = 128;
    localparam int FIELD_MAX_CHARS = 15;
    localparam int PREFIX_LEN      = 6;
    localparam int LAST_FIELD      = 9;

    localparam int LEN_W = $clog2(SENTENCE_BUFFER);
    localparam int CIF_W = $clog2(FIELD_MAX_CHARS + 1);

    localparam logic [7:0] C_DOLLAR   = 8'h24;
    localparam logic [7:0] C_CR       = 8'h0d;
    localparam logic [7:0] C_LF       = 8'h0a;
    localparam logic [7:0] C_NUL      = 8'h00;
    localparam logic [7:0] C_COMMA    = 8'h2c;
    localparam logic [7:0] C_STAR     = 8'h2a;
    localparam logic [7:0] C_QUESTION = 8'h3f;

    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_END    = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_NOT_RMC = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] field_number;
        logic [7:0] field_char;
        t_status    sentence_status;
        logic       last_of_run;
    } t_result;

    // expected prefix character at a given position
    function automatic logic [7:0] rmc_tag(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h52;
            3'd4:    ch = 8'h4d;
            3'd5:    ch = 8'h43;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/nrmc_ifs.sv
// ----------------------------------------------------------------------------
// nrmc_ifs
// valid/ready channels for received bytes and for parsed results
// ----------------------------------------------------------------------------
interface nrmc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] field_number;
    logic [7:0] field_char;
    logic [1:0] sentence_status;
    logic       last_of_run;

    modport source (output valid, output kind, output field_number, output field_char,
                    output sentence_status, output last_of_run, input ready);
    modport sink   (input valid, input kind, input field_number, input field_char,
                    input sentence_status, input last_of_run, output ready);
endinterface

>>> hdl/nmea_rmc_stream_field_splitter.sv
// ----------------------------------------------------------------------------
// nmea_rmc_stream_field_splitter
// frames nmea sentences and streams the fields of rmc sentences with a status
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  i_rx     in   rx_byte
//  o_res    out  kind, field_number, field_char, sentence_status, last_of_run
//
//  each byte is parsed in the cycle it is taken; its zero to three results go
//  into a three-entry result register and leave one per cycle while o_res is
//  ready; a new byte is taken when that register is empty or its last entry
//  leaves in the same cycle: one byte per cycle while each byte gives at most
//  one result and o_res is ready, else the next byte waits for the results
//  synchronous active-low reset clears the parser state and the result count
// ----------------------------------------------------------------------------
`include "nmea_rmc_stream_field_splitter_defines.svh"

module nmea_rmc_stream_field_splitter (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nrmc_byte_if.sink  i_rx,
    nrmc_res_if.source o_res
);
    import nrmc_pkg::*;

    // parser state
    logic             r_coll,  n_coll;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [2:0]       r_ppos,  n_ppos;
    logic             r_mism,  n_mism;
    logic [3:0]       r_cf,    n_cf;
    logic [CIF_W-1:0] r_cif,   n_cif;
    logic             r_skip,  n_skip;
    logic             r_ended, n_ended;

    // result register
    t_result    r_buf [3];
    logic [1:0] r_cnt;
    logic [1:0] r_rd;

    logic             accept, pop, field_open;
    logic             e_close, e_char, e_trunc, e_stat;
    t_status          stat;
    logic [7:0]       c;
    logic [CIF_W-1:0] cif_inc;
    t_result          slot [3];
    logic [1:0]       n_res;

    assign c          = i_rx.rx_byte;
    assign pop        = o_res.valid && o_res.ready;
    assign i_rx.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);
    assign accept     = i_rx.valid && i_rx.ready;
    assign field_open = r_coll && !r_ended && (r_cf != 4'd0) && !r_skip;
    assign cif_inc    = r_cif + CIF_W'(1);

    always_comb begin
        n_coll  = r_coll;
        n_len   = r_len;
        n_ppos  = r_ppos;
        n_mism  = r_mism;
        n_cf    = r_cf;
        n_cif   = r_cif;
        n_skip  = r_skip;
        n_ended = r_ended;
        e_close = 1'b0;
        e_char  = 1'b0;
        e_trunc = 1'b0;
        e_stat  = 1'b0;
        stat    = ST_OK;

        if (c == C_DOLLAR) begin
            // restart reports the sentence in progress as dropped
            e_stat  = r_coll;
            stat    = ST_DROPPED;
            n_coll  = 1'b1;
            n_len   = LEN_W'(1);
            n_ppos  = 3'd1;
            n_mism  = 1'b0;
            n_cf    = 4'd0;
            n_cif   = '0;
            n_skip  = 1'b1;
            n_ended = 1'b0;
        end else if (!r_coll || c == C_CR) begin
            n_coll = r_coll;
        end else if (c == C_LF) begin
            e_close = field_open;
            if (field_open) begin
                n_skip = 1'b1;
            end
            e_stat = 1'b1;
            if (r_ppos < 3'(PREFIX_LEN) || r_mism) begin
                stat = ST_NOT_RMC;
            end else if (r_cf >= 4'(LAST_FIELD)) begin
                stat = ST_OK;
            end else begin
                stat = ST_SHORT;
            end
            n_coll = 1'b0;
        end else if (r_len < LEN_W'(SENTENCE_BUFFER - 1)) begin
            n_len = r_len + LEN_W'(1);
            if (!r_ended) begin
                if (r_ppos < 3'(PREFIX_LEN)) begin
                    if (c != rmc_tag(r_ppos)) begin
                        n_mism = 1'b1;
                    end
                    n_ppos = r_ppos + 3'd1;
                    if (c == C_NUL) begin
                        n_ended = 1'b1;
                    end
                end else if (!r_mism) begin
                    case (c)
                        C_NUL: begin
                            e_close = field_open;
                            if (field_open) begin
                                n_skip = 1'b1;
                            end
                            n_ended = 1'b1;
                        end
                        C_COMMA: begin
                            e_close = field_open;
                            if (field_open) begin
                                n_skip = 1'b1;
                            end
                            if (r_cf < 4'(LAST_FIELD)) begin
                                n_cf   = r_cf + 4'd1;
                                n_skip = 1'b0;
                                n_cif  = '0;
                            end
                        end
                        C_STAR: begin
                            e_close = field_open;
                            if (field_open) begin
                                n_skip = 1'b1;
                            end
                        end
                        default: begin
                            if (field_open) begin
                                e_char = 1'b1;
                                n_cif  = cif_inc;
                                // field full: end it right after this character
                                if (cif_inc >= CIF_W'(FIELD_MAX_CHARS)) begin
                                    e_trunc = 1'b1;
                                    n_skip  = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
        end else begin
            // overflow
            e_stat = 1'b1;
            stat   = ST_DROPPED;
            n_coll = 1'b0;
            n_len  = '0;
        end
    end

    // pack the results of this byte in order
    always_comb begin
        slot[0] = '0;
        slot[1] = '0;
        slot[2] = '0;
        n_res   = 2'd0;
        if (e_close) begin
            if (r_cif == '0) begin
                slot[n_res] = '{kind: KIND_CHAR, field_number: r_cf, field_char: C_QUESTION,
                                sentence_status: ST_OK, last_of_run: 1'b0};
                n_res = n_res + 2'd1;
            end
            slot[n_res] = '{kind: KIND_END, field_number: r_cf, field_char: 8'h00,
                            sentence_status: ST_OK, last_of_run: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (e_char) begin
            slot[n_res] = '{kind: KIND_CHAR, field_number: r_cf, field_char: c,
                            sentence_status: ST_OK, last_of_run: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (e_trunc) begin
            slot[n_res] = '{kind: KIND_END, field_number: r_cf, field_char: 8'h00,
                            sentence_status: ST_OK, last_of_run: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (e_stat) begin
            slot[n_res] = '{kind: KIND_STATUS, field_number: 4'd0, field_char: 8'h00,
                            sentence_status: stat, last_of_run: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (n_res != 2'd0) begin
            slot[n_res - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll  <= 1'b0;
            r_len   <= '0;
            r_ppos  <= 3'd0;
            r_mism  <= 1'b0;
            r_cf    <= 4'd0;
            r_cif   <= '0;
            r_skip  <= 1'b0;
            r_ended <= 1'b0;
        end else if (accept) begin
            r_coll  <= n_coll;
            r_len   <= n_len;
            r_ppos  <= n_ppos;
            r_mism  <= n_mism;
            r_cf    <= n_cf;
            r_cif   <= n_cif;
            r_skip  <= n_skip;
            r_ended <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 2'd0;
        end else if (accept && n_res != 2'd0) begin
            r_cnt <= n_res;
            r_rd  <= 2'd0;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_res != 2'd0) begin
            r_buf[0] <= slot[0];
            r_buf[1] <= slot[1];
            r_buf[2] <= slot[2];
        end
    end

    assign o_res.valid           = (r_cnt != 2'd0);
    assign o_res.kind            = r_buf[r_rd].kind;
    assign o_res.field_number    = r_buf[r_rd].field_number;
    assign o_res.field_char      = r_buf[r_rd].field_char;
    assign o_res.sentence_status = r_buf[r_rd].sentence_status;
    assign o_res.last_of_run     = r_buf[r_rd].last_of_run;

    `NRMC_ASSERT(a_buf_bound, ({1'b0, r_rd} + {1'b0, r_cnt} <= 3'd3))
    `NRMC_ASSERT(a_last_drains, (pop && o_res.last_of_run) |-> (r_cnt == 2'd1))
    `NRMC_ASSERT(a_status_last, (o_res.valid && o_res.kind == KIND_STATUS) |-> o_res.last_of_run)
    `NRMC_ASSERT(a_prefix_bound, r_ppos <= 3'(PREFIX_LEN))
    `NRMC_ASSERT(a_idle_silent, (accept && !r_coll && c != C_DOLLAR) |=> (r_cnt == 2'd0 || $stable(r_rd)))

endmodule

>>> tb/nmea_rmc_stream_field_splitter_tb.sv
// ----------------------------------------------------------------------------
// nmea_rmc_stream_field_splitter_tb
// feeds framed and broken nmea sentences through the byte channel and checks
// every streamed field character, field end and sentence status against a
// cycle-free model of the splitter kept inside this bench
// ----------------------------------------------------------------------------
module nmea_rmc_stream_field_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    localparam int           REQ_TARGET  = 325;
    localparam int           HOLD_CYCLES = 150;
    localparam int           MAX_RESULTS = 3;
    localparam int           DIR_ROWS    = 27;
    localparam logic [47:0]  RMC_TAG     = "$GPRMC";

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_dir_row;

    localparam t_result NO_RES      = '0;
    localparam t_result RES_NOT_RMC = '{KIND_STATUS, 4'd0, 8'h00, ST_NOT_RMC, 1'b1};
    localparam t_result RES_DROPPED = '{KIND_STATUS, 4'd0, 8'h00, ST_DROPPED, 1'b1};
    localparam t_result RES_SHORT   = '{KIND_STATUS, 4'd0, 8'h00, ST_SHORT, 1'b1};

    logic clk = 1'b0;
    logic rst_n;

    nrmc_byte_if rx_if ();
    nrmc_res_if  res_if ();

    nmea_rmc_stream_field_splitter i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #2 clk = ~clk;

    // splitter model state
    logic       in_sentence;
    logic [6:0] sent_len;
    logic [2:0] tag_pos;
    logic       tag_bad;
    logic [3:0] field_idx;
    logic [4:0] field_chars;
    logic       skipping;
    logic       text_done;

    t_result  byte_results[$];
    t_result  rmc_awaited[$];
    t_dir_row dir_table [DIR_ROWS];

    int  busy_reqs;
    int  n_reqs;
    int  n_results;
    int  kind_seen [3];
    int  status_seen [4];
    int  fail_count;
    int  src_next_gap;
    bit  src_hot;
    bit  src_gaps;
    bit  snk_gaps;
    bit  hold_req;

    function automatic void add_result(input t_kind k, input logic [3:0] fnum,
                                       input logic [7:0] ch, input t_status st);
        t_result r;
        if (byte_results.size() >= MAX_RESULTS)
            return;
        r.kind            = k;
        r.field_number    = fnum;
        r.field_char      = ch;
        r.sentence_status = st;
        r.last_of_run     = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic bit field_is_open();
        return in_sentence && !text_done && field_idx >= 1 && !skipping;
    endfunction

    function automatic void close_if_open();
        if (field_is_open()) begin
            if (field_chars == 0)
                add_result(KIND_CHAR, field_idx, C_QUESTION, ST_OK);
            add_result(KIND_END, field_idx, 8'h00, ST_OK);
            skipping = 1'b1;
        end
    endfunction

    // advance the splitter by one byte, results land in byte_results
    function automatic void rmc_predict(input logic [7:0] c);
        t_status st;
        t_result r;
        byte_results.delete();
        if (in_sentence || c == C_DOLLAR)
            busy_reqs++;
        if (c == C_DOLLAR) begin
            if (in_sentence)
                add_result(KIND_STATUS, 4'd0, 8'h00, ST_DROPPED);
            in_sentence = 1'b1;
            sent_len    = 7'd1;
            tag_pos     = 3'd1;
            tag_bad     = 1'b0;
            field_idx   = 4'd0;
            field_chars = 5'd0;
            skipping    = 1'b1;
            text_done   = 1'b0;
        end else if (!in_sentence || c == C_CR) begin
            // nothing to do
        end else if (c == C_LF) begin
            close_if_open();
            if (tag_pos < PREFIX_LEN || tag_bad)
                st = ST_NOT_RMC;
            else if (field_idx >= LAST_FIELD)
                st = ST_OK;
            else
                st = ST_SHORT;
            add_result(KIND_STATUS, 4'd0, 8'h00, st);
            in_sentence = 1'b0;
        end else if (sent_len < SENTENCE_BUFFER - 1) begin
            sent_len++;
            if (text_done) begin
                // hidden behind a zero byte
            end else if (tag_pos < PREFIX_LEN) begin
                if (c != RMC_TAG[8 * (5 - int'(tag_pos)) +: 8])
                    tag_bad = 1'b1;
                tag_pos++;
                if (c == C_NUL)
                    text_done = 1'b1;
            end else if (tag_bad) begin
                // not rmc, text ignored
            end else if (c == C_NUL) begin
                close_if_open();
                text_done = 1'b1;
            end else if (c == C_COMMA) begin
                close_if_open();
                if (field_idx < LAST_FIELD) begin
                    field_idx++;
                    skipping    = 1'b0;
                    field_chars = 5'd0;
                end
            end else if (c == C_STAR) begin
                close_if_open();
            end else if (field_is_open()) begin
                add_result(KIND_CHAR, field_idx, c, ST_OK);
                field_chars++;
                if (field_chars >= FIELD_MAX_CHARS) begin
                    add_result(KIND_END, field_idx, 8'h00, ST_OK);
                    skipping = 1'b1;
                end
            end
        end else begin
            // overflow
            add_result(KIND_STATUS, 4'd0, 8'h00, ST_DROPPED);
            in_sentence = 1'b0;
            sent_len    = 7'd0;
        end
        if (byte_results.size() > 0) begin
            r = byte_results[byte_results.size() - 1];
            r.last_of_run = 1'b1;
            byte_results[byte_results.size() - 1] = r;
        end
    endfunction

    // one request on the byte channel; valid stays up when the next one follows at once
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result want = '0);
        repeat (src_next_gap) @(posedge clk);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        n_reqs++;
        rmc_predict(b);
        if (typed) begin
            byte_results.delete();
            byte_results.push_back(want);
        end
        foreach (byte_results[i])
            rmc_awaited.push_back(byte_results[i]);
        src_next_gap = src_gaps ? $urandom_range(0, 17) : 0;
        if (src_next_gap > 0)
            rx_if.valid <= 1'b0;
        src_hot = (src_next_gap == 0);
    endtask

    task automatic drain_results();
        if (src_hot) begin
            rx_if.valid <= 1'b0;
            src_hot = 1'b0;
        end
        while (rmc_awaited.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) begin
            do c = $urandom_range(1, 255);
            while (c == C_DOLLAR || c == C_LF || c == C_CR || c == C_COMMA || c == C_STAR);
        end else begin
            c = 8'h30 + $urandom_range(0, 42);
        end
        return c;
    endfunction

    task automatic send_random_sentence();
        int          pick;
        int          nfields;
        int          len;
        int          nul_at;
        logic [47:0] tag;
        logic [7:0]  c;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            // line noise, no sentence start
            repeat ($urandom_range(1, 6)) begin
                do c = $urandom_range(0, 255); while (c == C_DOLLAR);
                push_byte(c);
            end
            return;
        end
        tag = RMC_TAG;
        if (pick < 16)
            tag[8 * $urandom_range(0, 4) +: 8] = $urandom_range(0, 255);
        for (int i = 5; i >= 0; i--)
            push_byte(tag[8 * i +: 8]);
        if ($urandom_range(0, 3) == 0)
            push_byte(text_byte());
        nfields = (pick < 30) ? $urandom_range(0, 8) : $urandom_range(9, 11);
        nul_at  = (pick >= 16 && pick < 24 && nfields > 0) ? $urandom_range(1, nfields) : 0;
        for (int f = 1; f <= nfields; f++) begin
            push_byte(C_COMMA);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 17) : $urandom_range(0, 4);
            for (int k = 0; k < len; k++)
                push_byte(text_byte());
            if (f == nul_at)
                push_byte(C_NUL);
        end
        if ($urandom_range(0, 2) == 0) begin
            push_byte(C_STAR);
            push_byte(text_byte());
            push_byte(text_byte());
        end
        // left open now and then, the next start drops it
        if (pick >= 24 && pick < 30)
            return;
        if ($urandom_range(0, 1) == 0)
            push_byte(C_CR);
        push_byte(C_LF);
    endtask

    // long fields running past the buffer: truncation, then overflow
    task automatic send_overlong_sentence();
        for (int i = 5; i >= 0; i--)
            push_byte(RMC_TAG[8 * i +: 8]);
        for (int i = 0; i < 130; i++)
            push_byte((i % 18 == 0) ? C_COMMA : text_byte());
        push_byte(C_LF);
    endtask

    // result side: per-request stall, long hold when asked, check on accept
    initial begin
        int      stall;
        t_result got;
        t_result want;
        res_if.ready = 1'b0;
        snk_gaps     = 1'b1;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = snk_gaps ? $urandom_range(0, 17) : 0;
            end
            if ($urandom_range(0, 39) == 0)
                snk_gaps = !snk_gaps;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (res_if.valid !== 1'b1);
            got.kind            = t_kind'(res_if.kind);
            got.field_number    = res_if.field_number;
            got.field_char      = res_if.field_char;
            got.sentence_status = t_status'(res_if.sentence_status);
            got.last_of_run     = res_if.last_of_run;
            if (rmc_awaited.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result kind=%0d fnum=%0d char=%h st=%0d last=%0b",
                             $realtime, got.kind, got.field_number, got.field_char,
                             got.sentence_status, got.last_of_run);
            end else begin
                want = rmc_awaited.pop_front();
                n_results++;
                kind_seen[want.kind]++;
                if (want.kind == KIND_STATUS)
                    status_seen[want.sentence_status]++;
                if (got.kind !== want.kind || got.field_number !== want.field_number ||
                    got.field_char !== want.field_char ||
                    got.sentence_status !== want.sentence_status ||
                    got.last_of_run !== want.last_of_run) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp kind=%0d fnum=%0d char=%h st=%0d last=%0b",
                                 $realtime, want.kind, want.field_number, want.field_char,
                                 want.sentence_status, want.last_of_run,
                                 "  got kind=%0d fnum=%0d char=%h st=%0d last=%0b",
                                 got.kind, got.field_number, got.field_char,
                                 got.sentence_status, got.last_of_run);
                end
            end
        end
    end

    initial begin
        bit pressure_done;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        in_sentence   = 1'b0;
        sent_len      = 7'd0;
        tag_pos       = 3'd0;
        tag_bad       = 1'b0;
        field_idx     = 4'd0;
        field_chars   = 5'd0;
        skipping      = 1'b0;
        text_done     = 1'b0;
        src_next_gap  = 0;
        src_hot       = 1'b0;
        src_gaps      = 1'b1;
        hold_req      = 1'b0;
        pressure_done = 1'b0;

        dir_table = '{
            '{8'h00,    1'b0, NO_RES},       // idle bytes are dropped
            '{8'hff,    1'b0, NO_RES},
            '{C_DOLLAR, 1'b0, NO_RES},
            '{C_LF,     1'b1, RES_NOT_RMC},  // ends before the prefix
            '{C_DOLLAR, 1'b0, NO_RES},
            '{"G",      1'b0, NO_RES},
            '{"P",      1'b0, NO_RES},
            '{C_DOLLAR, 1'b1, RES_DROPPED},  // restart mid sentence
            '{"G",      1'b0, NO_RES},
            '{"P",      1'b0, NO_RES},
            '{"R",      1'b0, NO_RES},
            '{"M",      1'b0, NO_RES},
            '{"C",      1'b0, NO_RES},
            '{"X",      1'b0, NO_RES},       // text before the first comma
            '{C_COMMA,  1'b0, NO_RES},
            '{C_COMMA,  1'b0, NO_RES},       // empty field one
            '{"A",      1'b1, '{KIND_CHAR, 4'd2, "A", ST_OK, 1'b1}},
            '{8'hff,    1'b1, '{KIND_CHAR, 4'd2, 8'hff, ST_OK, 1'b1}},
            '{C_STAR,   1'b1, '{KIND_END, 4'd2, 8'h00, ST_OK, 1'b1}},
            '{"Z",      1'b0, NO_RES},
            '{C_CR,     1'b0, NO_RES},
            '{C_LF,     1'b1, RES_SHORT},
            '{C_DOLLAR, 1'b0, NO_RES},
            '{"G",      1'b0, NO_RES},
            '{"P",      1'b0, NO_RES},
            '{C_NUL,    1'b0, NO_RES},       // zero byte inside the prefix
            '{C_LF,     1'b1, RES_NOT_RMC}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            push_byte(dir_table[i].rx, dir_table[i].typed, dir_table[i].want);
        drain_results();

        while (busy_reqs < REQ_TARGET) begin
            if (!pressure_done && busy_reqs > 150) begin
                // sink holds off while requests keep coming back to back
                drain_results();
                src_gaps = 1'b0;
                hold_req = 1'b1;
                send_overlong_sentence();
                pressure_done = 1'b1;
            end
            src_gaps = ($urandom_range(0, 3) != 0);
            send_random_sentence();
        end
        drain_results();
        repeat (10) @(posedge clk);

        $display("covered %0d byte requests and %0d results: %0d chars, %0d field ends, %0d statuses",
                 n_reqs, n_results, kind_seen[KIND_CHAR], kind_seen[KIND_END],
                 kind_seen[KIND_STATUS]);
        $display("sentence statuses: ok %0d, short %0d, not rmc %0d, dropped %0d; failures %0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_NOT_RMC],
                 status_seen[ST_DROPPED], fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", rmc_awaited.size());
        $display("simulation failed");
        $finish;
    end

endmodule
